>>> hdl/assert_macros.svh
// Assertion macros shared by the hash engine RTL.
// Each macro places one labeled concurrent assertion on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_n is high.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, including during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bhe_pkg.sv
// Package for the BLAKE2b hash engine: state type, codes, IV and permutation tables.
// No dependencies.
package bhe_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_PAD,
    ST_INIT,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } state_t;

  localparam logic CFG_DLEN = 1'b0;
  localparam logic CFG_KLEN = 1'b1;
  localparam logic CMD_KEY = 1'b0;

  localparam logic [7:0] BLOCK_BYTES = 8'd128;
  localparam logic [4:0] STEP_DIAG = 5'd8;
  localparam logic [4:0] STEP_UNDIAG = 5'd17;
  localparam logic [3:0] LAST_ROUND = 4'd11;
  localparam logic [3:0] LAST_SROW = 4'd9;
  localparam logic [6:0] MAX_LEN = 7'd64;
  localparam logic [6:0] DLEN_RESET = 7'd64;
  localparam logic [6:0] KLEN_RESET = 7'd0;
  localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [3:0] sigma(input logic [3:0] row, input logic [3:0] pos);
    logic [63:0] w;
    unique case (row)
      4'd0: w = 64'hFEDCBA9876543210;
      4'd1: w = 64'h357B20C16DF984AE;
      4'd2: w = 64'h491763EADF250C8B;
      4'd3: w = 64'h8F04A562EBCD1397;
      4'd4: w = 64'hD386CB1EFA427509;
      4'd5: w = 64'h91EF57D438B0A6C2;
      4'd6: w = 64'hB8293670A4DEF15C;
      4'd7: w = 64'hA2684F05931CE7BD;
      4'd8: w = 64'h5A417D2C803B9EF6;
      4'd9: w = 64'h0DC3E9BF5167482A;
      default: w = 64'h0;
    endcase
    return w[{pos, 2'b00} +: 4];
  endfunction

  function automatic logic [6:0] eff_dlen(input logic [6:0] d);
    if (d == 7'd0) begin
      return 7'd1;
    end
    return (d > MAX_LEN) ? MAX_LEN : d;
  endfunction

  function automatic logic [6:0] eff_klen(input logic [6:0] k);
    return (k > MAX_LEN) ? MAX_LEN : k;
  endfunction

  function automatic logic [63:0] chain0(input logic [6:0] d, input logic [6:0] k);
    return IV[0] ^ PARAM_BASE ^ {49'd0, eff_klen(k), 8'd0} ^ {57'd0, eff_dlen(d)};
  endfunction

endpackage

>>> hdl/blake2b_hash_engine.sv
// BLAKE2b hash engine top level: word packing, shared half-G mixing unit, digest output.
// Depends on bhe_pkg and assert_macros.svh.
//
// Input channel: one beat carries a key word (cmd 0) or a message word (cmd 1),
// up to eight little-endian bytes, and last_word on the final message word.
// A beat is accepted when in_valid is high and in_stall is low; in_stall is high
// whenever the engine is busy with an earlier beat.
// A key word is inserted in one pass and the engine returns to idle; a message word
// that fits the block buffer is inserted, then checked for leftover bytes. A word
// that meets a full block buffer first starts a compression, runs it, and then
// inserts its remaining bytes into the fresh block. A compression has a setup
// state, 12 rounds on the single half-G unit (each 16 half-G steps plus two row
// rotations), and a chaining update state. The first message word of a keyed run
// adds a padding state. A last word that fits the buffer is padded and given its
// final compression before the first digest beat is raised.
// Result channel: after the last word, ceil(effective digest length / 8) digest beats
// follow, one per cycle, out_last_of_digest set on the final one. out_stall
// holds the current beat and the engine takes no input until the digest is drained.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken while idle and
// restart the run. Synchronous reset restores digest length 64, no key, and a
// fresh chaining state.
`include "assert_macros.svh"

module blake2b_hash_engine
  import bhe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last_of_digest,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  state_t      state_r, state_nxt;
  logic [6:0]  dlen_r, dlen_nxt, klen_r, klen_nxt;
  logic [63:0] chain_r [8];
  logic [63:0] chain_nxt [8];
  logic [63:0] cnt_lo_r, cnt_lo_nxt, cnt_hi_r, cnt_hi_nxt;
  logic [63:0] buf_r [16];
  logic [63:0] buf_nxt [16];
  logic [63:0] v_r [16];
  logic [63:0] v_nxt [16];
  logic [7:0]  fill_r, fill_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [63:0] data_r, data_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic        last_r, last_nxt;
  logic        key_mode_r, key_mode_nxt;
  logic        pad_final_r, pad_final_nxt;
  logic        final_r, final_nxt;
  logic [3:0]  round_r, round_nxt, srow_r, srow_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [6:0]  orem_r, orem_nxt;

  logic        in_acc, out_acc;
  logic [3:0]  in_bc;
  logic [6:0]  klen_eff;
  logic [7:0]  cap, room;
  logic [3:0]  n_ins;
  logic [3:0]  woff;
  logic [127:0] ins_data;
  logic [15:0] ins_mask;
  logic [3:0]  st_diag;
  logic [2:0]  g_idx;
  logic        half;
  logic [63:0] msg, a1, b1, c1, d1;
  logic        add_en;
  logic [7:0]  add_amt;
  logic [64:0] lo_sum;
  logic        restart;
  logic [63:0] rst_chain0;
  logic [3:0]  srow_exp;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_acc = out_valid && !out_stall;
  assign in_bc = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
  assign klen_eff = eff_klen(klen_r);

  assign cap = key_mode_r ? {1'b0, klen_eff} : BLOCK_BYTES;
  assign room = (fill_r < cap) ? (cap - fill_r) : 8'd0;
  assign n_ins = ({4'd0, rem_r} < room) ? rem_r : room[3:0];
  assign woff = {1'b0, fill_r[2:0]};
  assign ins_data = {64'd0, data_r} << {woff, 3'b000};
  assign ins_mask = ((16'h1 << n_ins) - 16'h1) << woff;

  assign st_diag = step_r[3:0] - 4'd9;
  assign g_idx = (step_r < STEP_DIAG) ? {1'b0, step_r[2:1]} : {1'b1, st_diag[2:1]};
  assign half = (step_r < STEP_DIAG) ? step_r[0] : st_diag[0];
  assign msg = buf_r[sigma(srow_r, {g_idx, half})];
  assign srow_exp = (round_r < 4'd10) ? round_r : round_r - 4'd10;

  always_comb begin
    logic [63:0] t;
    a1 = v_r[0] + v_r[4] + msg;
    t = v_r[12] ^ a1;
    d1 = half ? {t[15:0], t[63:16]} : {t[31:0], t[63:32]};
    c1 = v_r[8] + d1;
    t = v_r[4] ^ c1;
    b1 = half ? {t[62:0], t[63]} : {t[23:0], t[63:24]};
  end

  assign lo_sum = {1'b0, cnt_lo_r} + {57'd0, add_amt};
  assign rst_chain0 = chain0(dlen_nxt, klen_nxt);

  always_comb begin
    state_nxt = state_r;
    dlen_nxt = dlen_r;
    klen_nxt = klen_r;
    chain_nxt = chain_r;
    buf_nxt = buf_r;
    v_nxt = v_r;
    fill_nxt = fill_r;
    in_msg_nxt = in_msg_r;
    data_nxt = data_r;
    rem_nxt = rem_r;
    last_nxt = last_r;
    key_mode_nxt = key_mode_r;
    pad_final_nxt = pad_final_r;
    final_nxt = final_r;
    round_nxt = round_r;
    srow_nxt = srow_r;
    step_nxt = step_r;
    k_nxt = k_r;
    orem_nxt = orem_r;
    add_en = 1'b0;
    add_amt = 8'd0;
    restart = 1'b0;

    if (cfg_we && state_r == ST_IDLE) begin
      restart = 1'b1;
      unique case (cfg_index)
        CFG_DLEN: dlen_nxt = cfg_data;
        CFG_KLEN: klen_nxt = cfg_data;
        default: restart = 1'b1;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          data_nxt = in_data_word;
          rem_nxt = in_bc;
          last_nxt = in_last_word;
          if (in_cmd == CMD_KEY) begin
            key_mode_nxt = 1'b1;
            if (!in_msg_r && klen_eff != 7'd0) begin
              state_nxt = ST_INSERT;
            end
          end else begin
            key_mode_nxt = 1'b0;
            state_nxt = ST_INSERT;
            if (!in_msg_r) begin
              in_msg_nxt = 1'b1;
              if (klen_eff != 7'd0) begin
                pad_final_nxt = 1'b0;
                state_nxt = ST_PAD;
              end
            end
          end
        end
      end
      ST_INSERT: begin
        if (key_mode_r || (rem_r != 4'd0 && fill_r != BLOCK_BYTES)) begin
          for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 8; j++) begin
              if (i == int'(fill_r[6:3]) && ins_mask[j]) begin
                buf_nxt[i][8*j +: 8] = ins_data[8*j +: 8];
              end
              if (i == int'(fill_r[6:3]) + 1 && ins_mask[8+j]) begin
                buf_nxt[i][8*j +: 8] = ins_data[64+8*j +: 8];
              end
            end
          end
          fill_nxt = fill_r + {4'd0, n_ins};
          rem_nxt = rem_r - n_ins;
          data_nxt = (n_ins[3]) ? 64'd0 : (data_r >> {n_ins[2:0], 3'b000});
          if (key_mode_r) begin
            state_nxt = ST_IDLE;
          end
        end else if (rem_r != 4'd0) begin
          add_en = 1'b1;
          add_amt = BLOCK_BYTES;
          final_nxt = 1'b0;
          state_nxt = ST_INIT;
        end else if (last_r) begin
          pad_final_nxt = 1'b1;
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        for (int i = 0; i < 16; i++) begin
          for (int j = 0; j < 8; j++) begin
            if (8'(8*i + j) >= fill_r) begin
              buf_nxt[i][8*j +: 8] = 8'd0;
            end
          end
        end
        if (pad_final_r) begin
          add_en = 1'b1;
          add_amt = fill_r;
          final_nxt = 1'b1;
          state_nxt = ST_INIT;
        end else begin
          fill_nxt = BLOCK_BYTES;
          state_nxt = ST_INSERT;
        end
      end
      ST_INIT: begin
        for (int i = 0; i < 8; i++) begin
          v_nxt[i] = chain_r[i];
          v_nxt[i+8] = IV[i];
        end
        v_nxt[12] = IV[4] ^ cnt_lo_r;
        v_nxt[13] = IV[5] ^ cnt_hi_r;
        v_nxt[14] = IV[6] ^ {64{final_r}};
        round_nxt = 4'd0;
        srow_nxt = 4'd0;
        step_nxt = 5'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (step_r == STEP_DIAG) begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
              v_nxt[4*r+j] = v_r[4*r + (j+r)%4];
            end
          end
        end else if (step_r == STEP_UNDIAG) begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
              v_nxt[4*r+j] = v_r[4*r + (j-r+4)%4];
            end
          end
        end else if (!half) begin
          v_nxt[0] = a1;
          v_nxt[4] = b1;
          v_nxt[8] = c1;
          v_nxt[12] = d1;
        end else begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 3; j++) begin
              v_nxt[4*r+j] = v_r[4*r+j+1];
            end
          end
          v_nxt[3] = a1;
          v_nxt[7] = b1;
          v_nxt[11] = c1;
          v_nxt[15] = d1;
        end
        step_nxt = step_r + 5'd1;
        if (step_r == STEP_UNDIAG) begin
          step_nxt = 5'd0;
          round_nxt = round_r + 4'd1;
          srow_nxt = (srow_r == LAST_SROW) ? 4'd0 : srow_r + 4'd1;
          if (round_r == LAST_ROUND) begin
            state_nxt = ST_FEED;
          end
        end
      end
      ST_FEED: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] ^ v_r[i] ^ v_r[i+8];
        end
        if (final_r) begin
          k_nxt = 3'd0;
          orem_nxt = eff_dlen(dlen_r);
          state_nxt = ST_OUT;
        end else begin
          fill_nxt = 8'd0;
          state_nxt = ST_INSERT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (orem_r <= 7'd8) begin
            restart = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 3'd1;
            orem_nxt = orem_r - 7'd8;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    cnt_lo_nxt = add_en ? lo_sum[63:0] : cnt_lo_r;
    cnt_hi_nxt = (add_en && lo_sum[64]) ? cnt_hi_r + 64'd1 : cnt_hi_r;

    if (restart) begin
      for (int i = 1; i < 8; i++) begin
        chain_nxt[i] = IV[i];
      end
      chain_nxt[0] = rst_chain0;
      cnt_lo_nxt = 64'd0;
      cnt_hi_nxt = 64'd0;
      fill_nxt = 8'd0;
      in_msg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dlen_r <= DLEN_RESET;
      klen_r <= KLEN_RESET;
      for (int i = 1; i < 8; i++) begin
        chain_r[i] <= IV[i];
      end
      chain_r[0] <= chain0(DLEN_RESET, KLEN_RESET);
      cnt_lo_r <= 64'd0;
      cnt_hi_r <= 64'd0;
      fill_r <= 8'd0;
      in_msg_r <= 1'b0;
      rem_r <= 4'd0;
      last_r <= 1'b0;
      key_mode_r <= 1'b0;
      pad_final_r <= 1'b0;
      final_r <= 1'b0;
      round_r <= 4'd0;
      srow_r <= 4'd0;
      step_r <= 5'd0;
      k_r <= 3'd0;
      orem_r <= 7'd0;
    end else begin
      state_r <= state_nxt;
      dlen_r <= dlen_nxt;
      klen_r <= klen_nxt;
      chain_r <= chain_nxt;
      cnt_lo_r <= cnt_lo_nxt;
      cnt_hi_r <= cnt_hi_nxt;
      fill_r <= fill_nxt;
      in_msg_r <= in_msg_nxt;
      rem_r <= rem_nxt;
      last_r <= last_nxt;
      key_mode_r <= key_mode_nxt;
      pad_final_r <= pad_final_nxt;
      final_r <= final_nxt;
      round_r <= round_nxt;
      srow_r <= srow_nxt;
      step_r <= step_nxt;
      k_r <= k_nxt;
      orem_r <= orem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    v_r <= v_nxt;
    data_r <= data_nxt;
  end

  always_comb begin
    out_valid_bytes = (orem_r > 7'd8) ? 4'd8 : orem_r[3:0];
    out_last_of_digest = (orem_r <= 7'd8);
    for (int j = 0; j < 8; j++) begin
      out_digest_word[8*j +: 8] = (4'(j) < out_valid_bytes) ? chain_r[k_r][8*j +: 8] : 8'd0;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, !rst_n || fill_r <= BLOCK_BYTES, "fill count above block size")
  `ASSERT_CLK(a_srow_tracks_round, (state_r == ST_ROUND) |-> (srow_r == srow_exp), "row off")
  `ASSERT_CLK(a_no_input_while_out, out_valid |-> in_stall, "input open while digest pending")
  `ASSERT_CLK(a_final_to_out, (state_r == ST_FEED && final_r) |=> (state_r == ST_OUT), "no output")

endmodule

>>> verif/blake2b_hash_engine_tb.sv
// Self-checking testbench for blake2b_hash_engine: keyed and unkeyed BLAKE2b runs
// with random content, configuration changes, random idling and one long receiver hold.
// Depends on bhe_pkg and the engine RTL; carries its own BLAKE2b predictor.
`timescale 1ns / 100ps

module blake2b_hash_engine_tb;
  import bhe_pkg::*;

  localparam logic CMD_MSG = 1'b1;
  localparam int HALF_PERIOD = 6;
  localparam int SETTLE_CYCLES = 600;
  localparam int HOLD_CYCLES = 1500;
  localparam int TARGET_WORDS = 220;

  localparam int MSG_SCHED [10][16] = '{
    '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
    '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
    '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
    '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
    '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
    '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
    '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
    '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
    '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
    '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
  };

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        final_word;
  } digest_beat_t;

  class digest_tracker;
    logic [6:0]   dlen_reg;
    logic [6:0]   klen_reg;
    logic [63:0]  chain [8];
    logic [127:0] byte_total;
    logic [63:0]  blk [16];
    int           fill;
    bit           in_msg;
    digest_beat_t pending_digest [$];
    int           mismatches;

    function new();
      dlen_reg = DLEN_RESET;
      klen_reg = KLEN_RESET;
      mismatches = 0;
      restart();
    endfunction

    function int digest_bytes();
      int d;
      d = dlen_reg;
      if (d == 0) d = 1;
      if (d > 64) d = 64;
      return d;
    endfunction

    function int key_bytes();
      return (klen_reg > 64) ? 64 : int'(klen_reg);
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = IV[i];
      chain[0] ^= 64'h0101_0000 ^ (64'(key_bytes()) << 8) ^ 64'(digest_bytes());
      byte_total = '0;
      for (int i = 0; i < 16; i++) blk[i] = '0;
      fill = 0;
      in_msg = 0;
    endfunction

    function void set_reg(logic idx, logic [6:0] val);
      if (idx == CFG_DLEN) dlen_reg = val;
      else klen_reg = val;
      restart();
    endfunction

    function void put_byte(int pos, logic [7:0] b);
      blk[pos / 8][(pos % 8) * 8 +: 8] = b;
    endfunction

    function void zero_tail();
      for (int p = fill; p < 128; p++) put_byte(p, 8'h00);
    endfunction

    function logic [63:0] rotr(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void mix_g(ref logic [63:0] v [16], input int a, int b, int c, int d,
                        input logic [63:0] x, logic [63:0] y);
      v[a] = v[a] + v[b] + x;
      v[d] = rotr(v[d] ^ v[a], 32);
      v[c] = v[c] + v[d];
      v[b] = rotr(v[b] ^ v[c], 24);
      v[a] = v[a] + v[b] + y;
      v[d] = rotr(v[d] ^ v[a], 16);
      v[c] = v[c] + v[d];
      v[b] = rotr(v[b] ^ v[c], 63);
    endfunction

    function void compress(bit last_block);
      logic [63:0] v [16];
      int s [16];
      for (int i = 0; i < 8; i++) begin
        v[i] = chain[i];
        v[i + 8] = IV[i];
      end
      v[12] ^= byte_total[63:0];
      v[13] ^= byte_total[127:64];
      if (last_block) v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
        for (int j = 0; j < 16; j++) s[j] = MSG_SCHED[r % 10][j];
        mix_g(v, 0, 4,  8, 12, blk[s[0]],  blk[s[1]]);
        mix_g(v, 1, 5,  9, 13, blk[s[2]],  blk[s[3]]);
        mix_g(v, 2, 6, 10, 14, blk[s[4]],  blk[s[5]]);
        mix_g(v, 3, 7, 11, 15, blk[s[6]],  blk[s[7]]);
        mix_g(v, 0, 5, 10, 15, blk[s[8]],  blk[s[9]]);
        mix_g(v, 1, 6, 11, 12, blk[s[10]], blk[s[11]]);
        mix_g(v, 2, 7,  8, 13, blk[s[12]], blk[s[13]]);
        mix_g(v, 3, 4,  9, 14, blk[s[14]], blk[s[15]]);
      end
      for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i + 8];
    endfunction

    function void note_word(logic cmd, logic [63:0] data, logic [3:0] cnt, logic last);
      int nb;
      int kl;
      int dl;
      int nw;
      int vb;
      digest_beat_t e;
      nb = (cnt > 8) ? 8 : int'(cnt);
      kl = key_bytes();
      if (cmd == CMD_KEY) begin
        if (!in_msg && kl > 0) begin
          for (int i = 0; i < nb; i++) begin
            if (fill < kl) begin
              put_byte(fill, data[8 * i +: 8]);
              fill++;
            end
          end
        end
        return;
      end
      if (!in_msg) begin
        in_msg = 1;
        if (kl > 0) begin
          zero_tail();
          fill = 128;
        end
      end
      for (int i = 0; i < nb; i++) begin
        if (fill >= 128) begin
          byte_total += 128;
          compress(0);
          fill = 0;
        end
        put_byte(fill, data[8 * i +: 8]);
        fill++;
      end
      if (!last) return;
      byte_total += fill;
      zero_tail();
      compress(1);
      dl = digest_bytes();
      nw = (dl + 7) / 8;
      for (int k = 0; k < nw; k++) begin
        vb = dl - 8 * k;
        if (vb > 8) vb = 8;
        e.word = chain[k];
        if (vb < 8) e.word &= (64'd1 << (8 * vb)) - 64'd1;
        e.nbytes = 4'(vb);
        e.final_word = (k + 1 == nw);
        pending_digest.push_back(e);
      end
      restart();
    endfunction

    function void check_digest_word(logic [63:0] word, logic [3:0] nbytes, logic fin);
      digest_beat_t e;
      if (pending_digest.size() == 0) begin
        $display("%0t: digest beat expected none actual %h", $time, word);
        mismatches++;
        return;
      end
      e = pending_digest.pop_front();
      if (word !== e.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
        mismatches++;
      end
      if (nbytes !== e.nbytes) begin
        $display("%0t: valid_bytes expected %0d actual %0d", $time, e.nbytes, nbytes);
        mismatches++;
      end
      if (fin !== e.final_word) begin
        $display("%0t: last_of_digest expected %b actual %b", $time, e.final_word, fin);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [63:0] in_data_word;
  logic [3:0]  in_byte_count;
  logic        in_last_word;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_digest_word;
  logic [3:0]  out_valid_bytes;
  logic        out_last_of_digest;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  digest_tracker board;
  int words_sent;
  int beats_seen;
  int hold_left;
  bit hold_done;
  bit send_gaps;
  bit recv_gaps;

  blake2b_hash_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_data_word(in_data_word), .in_byte_count(in_byte_count),
    .in_last_word(in_last_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest_word(out_digest_word),
    .out_valid_bytes(out_valid_bytes), .out_last_of_digest(out_last_of_digest),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(logic cmd, logic [63:0] data, logic [3:0] cnt, logic last);
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data_word <= data;
    in_byte_count <= cnt;
    in_last_word <= last;
    do @(posedge clk); while (in_stall);
    board.note_word(cmd, data, cnt, last);
    words_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_digest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_key(int nbytes);
    int left;
    left = nbytes;
    while (left > 0) begin
      send_word(CMD_KEY, pick_data(), 4'((left > 8) ? 8 : left), 1'b0);
      left -= 8;
    end
  endtask

  // One hash run; a noisy run mixes in stray key beats and short inner words.
  task automatic send_run(bit noisy);
    int nwords;
    int r;
    logic [3:0] cnt;
    send_gaps = ($urandom_range(0, 3) != 0);
    send_key(($urandom_range(0, 7) == 0) ? $urandom_range(0, 72) : board.key_bytes());
    r = $urandom_range(0, 9);
    nwords = (r < 6) ? $urandom_range(0, 6) : (r < 9) ? $urandom_range(7, 20)
                     : $urandom_range(30, 50);
    for (int i = 0; i < nwords; i++) begin
      if (noisy && $urandom_range(0, 3) == 0) begin
        send_word(CMD_KEY, pick_data(), 4'($urandom_range(0, 15)), 1'($urandom));
      end
      cnt = (noisy && $urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      send_word(CMD_MSG, pick_data(), cnt, 1'b0);
    end
    send_word(CMD_MSG, pick_data(), 4'($urandom_range(0, 15)), 1'b1);
  endtask

  function automatic logic [6:0] pick_len(bit key_reg);
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd64;
    if (r == 2) return 7'd127;
    if (r == 3) return key_reg ? 7'd0 : 7'd1;
    return 7'($urandom_range(0, 127));
  endfunction

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      board.check_digest_word(out_digest_word, out_valid_bytes, out_last_of_digest);
      beats_seen++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (beats_seen >= 5 && !hold_done) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_gaps = ~recv_gaps;
      if (!recv_gaps) out_stall <= 1'b0;
      else if ($urandom_range(0, 49) == 0) begin
        hold_left = $urandom_range(10, 40);
        out_stall <= 1'b1;
      end else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #(1_000_000 * 2 * HALF_PERIOD);
    $display("status: fail");
    $finish;
  end

  initial begin
    board = new();
    words_sent = 0;
    beats_seen = 0;
    hold_left = 0;
    hold_done = 0;
    send_gaps = 1;
    recv_gaps = 1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_KEY;
    in_data_word <= '0;
    in_byte_count <= '0;
    in_last_word <= 1'b0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DLEN;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unkeyed defaults: empty message, a stray key beat with last set, "abc", a two-word message.
    send_word(CMD_MSG, '0, 4'd0, 1'b1);
    send_word(CMD_KEY, '1, 4'd8, 1'b1);
    send_word(CMD_MSG, 64'h0000_0000_0063_6261, 4'd3, 1'b1);
    send_word(CMD_MSG, '1, 4'd8, 1'b0);
    send_word(CMD_MSG, '1, 4'd15, 1'b1);
    settle();

    // Full key with a one-byte digest: keyed empty message, then a short key.
    write_reg(CFG_DLEN, 7'd0);
    write_reg(CFG_KLEN, 7'd127);
    for (int i = 0; i < 8; i++) send_word(CMD_KEY, '1, 4'd8, 1'b0);
    send_word(CMD_MSG, '0, 4'd0, 1'b1);
    send_key(20);
    for (int i = 0; i < 16; i++) send_word(CMD_MSG, pick_data(), 4'd8, 1'b0);
    send_word(CMD_MSG, pick_data(), 4'd1, 1'b1);
    settle();

    // One-byte key with extra key bytes, byte-packed inner word, late key beat.
    write_reg(CFG_DLEN, 7'd33);
    write_reg(CFG_KLEN, 7'd1);
    send_word(CMD_KEY, 64'h0123_4567_89ab_cdef, 4'd8, 1'b0);
    send_word(CMD_MSG, 64'hfedc_ba98_7654_3210, 4'd3, 1'b0);
    send_word(CMD_KEY, '1, 4'd8, 1'b0);
    send_word(CMD_MSG, pick_data(), 4'd7, 1'b1);
    settle();

    while (words_sent < TARGET_WORDS) begin
      if ($urandom_range(0, 1) == 0) write_reg(CFG_DLEN, pick_len(0));
      if ($urandom_range(0, 1) == 0) write_reg(CFG_KLEN, pick_len(1));
      repeat ($urandom_range(1, 3)) send_run($urandom_range(0, 9) == 0);
      settle();
    end

    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bhe_pkg.sv
hdl/blake2b_hash_engine.sv
verif/blake2b_hash_engine_tb.sv
